### hdl/uuse_pkg.sv
// ----------------------------------------------------------------------------
// uuse_pkg
// Shared types, constants and character helpers of the uuencode stream encoder.
// ----------------------------------------------------------------------------
package uuse_pkg;

	localparam int BYTES_PER_LINE_DEF = 45;
	localparam int QUEUE_DEPTH_DEF    = 4;
	localparam int NSTEP              = 12;

	localparam logic [6:0] CH_BQ = 7'h60;
	localparam logic [6:0] CH_NL = 7'h0a;
	localparam logic [6:0] CH_E  = 7'h65;
	localparam logic [6:0] CH_N  = 7'h6e;
	localparam logic [6:0] CH_D  = 7'h64;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// work for the back end, produced by one request
	typedef struct packed {
		logic       len_en;
		logic [5:0] len_val;
		logic       grp_en;
		logic [7:0] grp_a;
		logic [7:0] grp_b;
		logic [7:0] grp_c;
		logic [1:0] grp_cnt;
		logic       nl_en;
		logic       trl_en;
	} cmd_t;

	function automatic logic [6:0] enc6(input logic [5:0] v);
		return (v == 6'd0) ? CH_BQ : (7'h20 + {1'b0, v});
	endfunction

endpackage

### hdl/uuse_in_if.sv
// ----------------------------------------------------------------------------
// uuse_in_if
// Request channel: operation and message byte.
// ----------------------------------------------------------------------------
interface uuse_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source(output valid, operation, data_byte, input ready);
	modport sink(input valid, operation, data_byte, output ready);
endinterface

### hdl/uuse_out_if.sv
// ----------------------------------------------------------------------------
// uuse_out_if
// Text channel: one encoded character per transfer.
// ----------------------------------------------------------------------------
interface uuse_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       run_last;
	logic       message_end;

	modport source(output valid, out_char, run_last, message_end, input ready);
	modport sink(input valid, out_char, run_last, message_end, output ready);
endinterface

### hdl/uuse_cfg_if.sv
// ----------------------------------------------------------------------------
// uuse_cfg_if
// Configuration write channel for the message length register.
// ----------------------------------------------------------------------------
interface uuse_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_length;

	modport source(output valid, message_length, input ready);
	modport sink(input valid, message_length, output ready);
endinterface

### hdl/uuse_front.sv
// ----------------------------------------------------------------------------
// uuse_front
// Accepts requests, tracks message and line position, collects byte groups
// and hands at most one command per request to the queue.
// ----------------------------------------------------------------------------
module uuse_front #(
	parameter int BYTES_PER_LINE = uuse_pkg::BYTES_PER_LINE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	uuse_cfg_if.sink      cfg,
	uuse_in_if.sink       cmd,
	input  logic          full,
	output logic          push,
	output uuse_pkg::cmd_t push_data
);
	import uuse_pkg::*;

	localparam int LFW = $clog2(BYTES_PER_LINE + 1);

	logic [31:0]    msg_len_q;
	logic [31:0]    rem_q, rem_d, rem_dec;
	logic [LFW-1:0] fill_q, fill_d, fill_inc;
	logic [7:0]     h0_q, h0_d, h1_q, h1_d;
	logic [1:0]     phase_q, phase_d;
	logic           accept;
	cmd_t           c;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !full;
	assign accept    = cmd.valid && !full;
	assign rem_dec   = rem_q - 32'd1;
	assign fill_inc  = fill_q + LFW'(1);

	always_comb begin
		rem_d   = rem_q;
		fill_d  = fill_q;
		h0_d    = h0_q;
		h1_d    = h1_q;
		phase_d = phase_q;
		c       = '0;
		if (cmd.operation == OP_START) begin
			rem_d   = msg_len_q;
			fill_d  = '0;
			h0_d    = '0;
			h1_d    = '0;
			phase_d = 2'd0;
			c.trl_en = (msg_len_q == 32'd0);
		end else if (rem_q != 32'd0) begin
			if (fill_q == '0) begin
				c.len_en  = 1'b1;
				c.len_val = (rem_q > 32'(BYTES_PER_LINE)) ? 6'(BYTES_PER_LINE) : rem_q[5:0];
			end
			case (phase_q)
				2'd0: begin
					h0_d    = cmd.data_byte;
					phase_d = 2'd1;
				end
				2'd1: begin
					h1_d    = cmd.data_byte;
					phase_d = 2'd2;
				end
				default: begin
					c.grp_en  = 1'b1;
					c.grp_a   = h0_q;
					c.grp_b   = h1_q;
					c.grp_c   = cmd.data_byte;
					c.grp_cnt = 2'd3;
					phase_d   = 2'd0;
				end
			endcase
			rem_d  = rem_dec;
			fill_d = fill_inc;
			if (fill_inc >= LFW'(BYTES_PER_LINE) || rem_dec == 32'd0) begin
				// flush a partial group, close the line
				if (phase_d == 2'd1) begin
					c.grp_en  = 1'b1;
					c.grp_a   = h0_d;
					c.grp_b   = '0;
					c.grp_c   = '0;
					c.grp_cnt = 2'd1;
				end else if (phase_d == 2'd2) begin
					c.grp_en  = 1'b1;
					c.grp_a   = h0_d;
					c.grp_b   = h1_d;
					c.grp_c   = '0;
					c.grp_cnt = 2'd2;
				end
				phase_d  = 2'd0;
				fill_d   = '0;
				c.nl_en  = 1'b1;
				c.trl_en = (rem_dec == 32'd0);
			end
		end
	end

	assign push      = accept && (c.len_en || c.grp_en || c.nl_en || c.trl_en);
	assign push_data = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= '0;
			rem_q     <= '0;
			fill_q    <= '0;
			h0_q      <= '0;
			h1_q      <= '0;
			phase_q   <= 2'd0;
		end else begin
			if (cfg.valid)
				msg_len_q <= cfg.message_length;
			if (accept) begin
				rem_q   <= rem_d;
				fill_q  <= fill_d;
				h0_q    <= h0_d;
				h1_q    <= h1_d;
				phase_q <= phase_d;
			end
		end
	end

endmodule

### hdl/uuse_queue.sv
// ----------------------------------------------------------------------------
// uuse_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module uuse_queue #(
	parameter int DEPTH = uuse_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uuse_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output uuse_pkg::cmd_t pop_data,
	output logic           empty
);
	import uuse_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

### hdl/uuse_back.sv
// ----------------------------------------------------------------------------
// uuse_back
// Steps through the characters of each command, one per cycle while txt
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module uuse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  uuse_pkg::cmd_t head,
	output logic           pop,
	uuse_out_if.source     txt
);
	import uuse_pkg::*;

	localparam logic [3:0] STEP_LEN    = 4'd0;
	localparam logic [3:0] STEP_G0     = 4'd1;
	localparam logic [3:0] STEP_G1     = 4'd2;
	localparam logic [3:0] STEP_G2     = 4'd3;
	localparam logic [3:0] STEP_G3     = 4'd4;
	localparam logic [3:0] STEP_NL     = 4'd5;
	localparam logic [3:0] STEP_T_BQ   = 4'd6;
	localparam logic [3:0] STEP_T_NL   = 4'd7;
	localparam logic [3:0] STEP_T_E    = 4'd8;
	localparam logic [3:0] STEP_T_N    = 4'd9;
	localparam logic [3:0] STEP_T_D    = 4'd10;
	localparam logic [3:0] STEP_END_NL = 4'd11;

	function automatic logic [NSTEP-1:0] mask_of(input cmd_t c);
		return {{6{c.trl_en}}, c.nl_en, {4{c.grp_en}}, c.len_en};
	endfunction

	function automatic logic [3:0] first_set(input logic [NSTEP-1:0] m, input logic [3:0] from);
		logic [3:0] idx;
		idx = '0;
		for (int i = NSTEP - 1; i >= 0; i--) begin
			if (m[i] && i >= int'(from))
				idx = 4'(i);
		end
		return idx;
	endfunction

	cmd_t             cur_q;
	logic [3:0]       step_q;
	logic             busy_q;
	logic [NSTEP-1:0] cur_mask, later_mask;
	logic             can_load, emit, done;
	logic [6:0]       ch;
	logic             valid_q, last_q, end_q;
	logic [6:0]       char_q;

	assign cur_mask   = mask_of(cur_q);
	assign later_mask = cur_mask & ({NSTEP{1'b1}} << (5'(step_q) + 5'd1));
	assign can_load   = !valid_q || txt.ready;
	assign emit       = busy_q && can_load;
	assign done       = emit && (later_mask == '0);
	assign pop        = !empty && (!busy_q || done);

	always_comb begin
		case (step_q)
			STEP_LEN:    ch = enc6(cur_q.len_val);
			STEP_G0:     ch = enc6(cur_q.grp_a[7:2]);
			STEP_G1:     ch = enc6({cur_q.grp_a[1:0], cur_q.grp_b[7:4]});
			STEP_G2:     ch = (cur_q.grp_cnt >= 2'd2) ?
				enc6({cur_q.grp_b[3:0], cur_q.grp_c[7:6]}) : CH_BQ;
			STEP_G3:     ch = (cur_q.grp_cnt == 2'd3) ? enc6(cur_q.grp_c[5:0]) : CH_BQ;
			STEP_NL:     ch = CH_NL;
			STEP_T_BQ:   ch = CH_BQ;
			STEP_T_NL:   ch = CH_NL;
			STEP_T_E:    ch = CH_E;
			STEP_T_N:    ch = CH_N;
			STEP_T_D:    ch = CH_D;
			STEP_END_NL: ch = CH_NL;
			default:     ch = CH_BQ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (emit) begin
			char_q <= ch;
			last_q <= (later_mask == '0);
			end_q  <= (step_q == STEP_END_NL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_LEN;
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q <= first_set(mask_of(head), STEP_LEN);
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				step_q <= first_set(cur_mask, step_q + 4'd1);
			end
			if (emit)
				valid_q <= 1'b1;
			else if (txt.ready)
				valid_q <= 1'b0;
		end
	end

	assign txt.valid       = valid_q;
	assign txt.out_char    = char_q;
	assign txt.run_last    = last_q;
	assign txt.message_end = end_q;

	a_step_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cur_mask[step_q])
		else $error("back end on a disabled step");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && end_q |-> last_q && char_q == CH_NL)
		else $error("trailer end not on final newline");

	a_no_pop_mid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !done |-> !pop)
		else $error("command taken while one is in progress");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> valid_q)
		else $error("emitted character lost");

endmodule

### hdl/uuencode_stream_encoder.sv
// ----------------------------------------------------------------------------
// uuencode_stream_encoder
// Streams message bytes into uuencoded text, one character per transfer.
//
// Write the byte count on cfg, then send a start request (operation 0)
// on cmd followed by the data bytes (operation 1). Text comes out on txt:
// a length character opening each line, four characters per three bytes,
// a newline per line and the trailer after the last byte. run_last marks
// the last character a request causes; message_end marks the trailer end.
// Bytes past the configured count are dropped.
// cmd takes one request per cycle while the command queue has room; the
// back end emits one character per cycle while txt is not stalled, and a
// request produces up to 12 characters. A taken request passes through
// the command queue, the back end's command register and the output
// register before its first character is valid on txt.
// When txt stalls the output register holds, the queue fills and cmd
// drops ready. Reset clears the length register, message state and queue.
// ----------------------------------------------------------------------------
module uuencode_stream_encoder #(
	parameter int BYTES_PER_LINE = uuse_pkg::BYTES_PER_LINE_DEF,
	parameter int QUEUE_DEPTH    = uuse_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	uuse_cfg_if.sink   cfg,
	uuse_in_if.sink    cmd,
	uuse_out_if.source txt
);
	import uuse_pkg::*;

	cmd_t push_data, head;
	logic push, full, pop, empty;

	uuse_front #(
		.BYTES_PER_LINE(BYTES_PER_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	uuse_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (head),
		.empty    (empty)
	);

	uuse_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.head  (head),
		.pop   (pop),
		.txt   (txt)
	);

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the uuencode stream encoder. A queue of requests
// (directed cases first, then random messages of mixed length) feeds a
// bursty driver; a clocked monitor predicts the encoded text of every taken
// request and checks each character leaving the block against it.
// ----------------------------------------------------------------------------
module tb_top;
	import uuse_pkg::*;

	localparam int LINE_BYTES   = BYTES_PER_LINE_DEF;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int RAND_ITEMS   = 170;

	typedef struct {
		logic       op;
		logic [7:0] data;
	} req_t;

	typedef struct {
		logic [6:0] ch;
		logic       run_last;
		logic       msg_end;
	} uu_char_t;

	logic clk = 1'b0;
	logic arst_n;

	uuse_cfg_if cfg_bus();
	uuse_in_if  cmd_bus();
	uuse_out_if txt_bus();

	uuencode_stream_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.txt    (txt_bus)
	);

	always #10 clk = ~clk;

	req_t     req_q[$];
	uu_char_t text_q[$];
	int       err_cnt   = 0;
	int       cycle_cnt = 0;
	logic     req_taken;

	// encoder state mirror
	logic [31:0] msg_len    = '0;
	logic [31:0] bytes_left = '0;
	logic [5:0]  line_fill  = '0;
	logic [7:0]  grp_hold[2] = '{8'h00, 8'h00};
	logic [1:0]  grp_cnt    = '0;

	// sender burst control
	int burst_left = 0;
	int gap_left   = 0;

	// receiver stall control
	int rx_mode      = 0;
	int rx_mode_left = 0;
	int rx_tick      = 0;
	int hold_left    = 0;
	bit long_armed   = 1'b0;
	bit long_done    = 1'b0;

	function automatic logic [6:0] to_uu(input logic [5:0] v);
		if (v == 6'd0)
			return CH_BQ;
		return 7'h20 + 7'(v);
	endfunction

	task automatic push_char(input logic [6:0] c, input logic mend);
		text_q.push_back('{c, 1'b0, mend});
	endtask

	task automatic push_group(input logic [7:0] a, input logic [7:0] b,
				  input logic [7:0] c, input int n);
		push_char(to_uu(a[7:2]), 1'b0);
		push_char(to_uu({a[1:0], b[7:4]}), 1'b0);
		push_char(n >= 2 ? to_uu({b[3:0], c[7:6]}) : to_uu(6'd0), 1'b0);
		push_char(n >= 3 ? to_uu(c[5:0]) : to_uu(6'd0), 1'b0);
	endtask

	task automatic push_trailer();
		push_char(CH_BQ, 1'b0);
		push_char(CH_NL, 1'b0);
		push_char(CH_E, 1'b0);
		push_char(CH_N, 1'b0);
		push_char(CH_D, 1'b0);
		push_char(CH_NL, 1'b1);
	endtask

	task automatic encode_request(input logic op, input logic [7:0] b);
		int first;
		first = text_q.size();
		if (op == OP_START) begin
			bytes_left  = msg_len;
			line_fill   = '0;
			grp_hold[0] = '0;
			grp_hold[1] = '0;
			grp_cnt     = '0;
			if (bytes_left == 0)
				push_trailer();
		end else if (bytes_left != 0) begin
			if (line_fill == 0)
				push_char(to_uu(bytes_left > LINE_BYTES ? 6'(LINE_BYTES) : bytes_left[5:0]),
					  1'b0);
			case (grp_cnt)
				2'd0: begin
					grp_hold[0] = b;
					grp_cnt     = 2'd1;
				end
				2'd1: begin
					grp_hold[1] = b;
					grp_cnt     = 2'd2;
				end
				default: begin
					push_group(grp_hold[0], grp_hold[1], b, 3);
					grp_cnt = 2'd0;
				end
			endcase
			bytes_left = bytes_left - 1;
			line_fill  = line_fill + 6'd1;
			if (line_fill >= LINE_BYTES || bytes_left == 0) begin
				if (grp_cnt == 2'd1)
					push_group(grp_hold[0], 8'h00, 8'h00, 1);
				else if (grp_cnt == 2'd2)
					push_group(grp_hold[0], grp_hold[1], 8'h00, 2);
				grp_cnt   = 2'd0;
				push_char(CH_NL, 1'b0);
				line_fill = '0;
				if (bytes_left == 0)
					push_trailer();
			end
		end
		if (text_q.size() > first)
			text_q[text_q.size() - 1].run_last = 1'b1;
	endtask

	task automatic log_error(input string what, input uu_char_t exp_c, input uu_char_t act_c);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0s at cycle %0d: expected char %h run_last %b end %b, ",
				 what, cycle_cnt, exp_c.ch, exp_c.run_last, exp_c.msg_end,
				 "got char %h run_last %b end %b",
				 act_c.ch, act_c.run_last, act_c.msg_end);
	endtask

	// request acceptance, prediction and text check
	always @(posedge clk) begin
		uu_char_t got;
		uu_char_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			cycle_cnt++;
			req_taken <= cmd_bus.valid && cmd_bus.ready;
			if (cmd_bus.valid && cmd_bus.ready) begin
				encode_request(req_q[0].op, req_q[0].data);
				void'(req_q.pop_front());
			end
			if (txt_bus.valid && txt_bus.ready) begin
				got = '{txt_bus.out_char, txt_bus.run_last, txt_bus.message_end};
				if (text_q.size() == 0) begin
					want = '{7'h00, 1'b0, 1'b0};
					log_error("unexpected character", want, got);
				end else begin
					want = text_q.pop_front();
					if (got.ch !== want.ch || got.run_last !== want.run_last ||
					    got.msg_end !== want.msg_end)
						log_error("mismatch", want, got);
				end
			end
			if (cycle_cnt > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_cnt);
				$display("FAIL");
				$finish;
			end
		end
	end

	// request driver: bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
		end else if (cmd_bus.valid && !req_taken) begin
			// request still pending, hold it
		end else begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 5) == 0) begin
					burst_left = 100;
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = $urandom_range(0, 8);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				cmd_bus.valid <= 1'b0;
			end else if (req_q.size() > 0) begin
				cmd_bus.valid     <= 1'b1;
				cmd_bus.operation <= req_q[0].op;
				cmd_bus.data_byte <= req_q[0].data;
				burst_left--;
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// text receiver: changing stall patterns plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			txt_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			txt_bus.ready <= 1'b0;
		end else if (long_armed && !long_done && text_q.size() > 0) begin
			long_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			txt_bus.ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(10, 80);
			end
			rx_mode_left--;
			rx_tick++;
			case (rx_mode)
				0:       txt_bus.ready <= 1'b1;
				1:       txt_bus.ready <= ($urandom_range(0, 3) != 0);
				2:       txt_bus.ready <= ($urandom_range(0, 1) != 0);
				default: txt_bus.ready <= ((rx_tick % 7) < 4);
			endcase
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_req(input logic op, input logic [7:0] b);
		req_q.push_back('{op, b});
	endtask

	task automatic wait_text_drained();
		while (req_q.size() != 0 || cmd_bus.valid || text_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_msg_len(input logic [31:0] v);
		wait_text_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid          <= 1'b1;
		cfg_bus.message_length <= v;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		msg_len = v;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_message(input logic [31:0] len, input int nbytes, input bit noise,
				     input int pause_at, input int restart_at, output int counted);
		counted = 1;
		if (noise)
			push_req(OP_DATA, rand_byte());
		push_req(OP_START, rand_byte());
		for (int i = 0; i < nbytes; i++) begin
			if (i == restart_at) begin
				push_req(OP_START, rand_byte());
				counted++;
			end
			if (i == pause_at)
				wait_text_drained();
			push_req(OP_DATA, rand_byte());
			if (i < len)
				counted++;
		end
	endtask

	initial begin
		logic [31:0] len;
		int          nb;
		int          n;
		int          rand_items;
		int          pause_at;
		int          restart_at;
		bit          noise;
		bit          first;

		arst_n                 = 1'b0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.message_length = '0;
		cmd_bus.valid          = 1'b0;
		cmd_bus.operation      = OP_START;
		cmd_bus.data_byte      = '0;
		txt_bus.ready          = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte with no message open
		push_req(OP_DATA, 8'hFF);
		// empty message: trailer only
		set_msg_len(32'd0);
		push_req(OP_START, 8'hFF);
		// zero byte encodes to backquote
		set_msg_len(32'd1);
		push_req(OP_START, 8'h00);
		push_req(OP_DATA, 8'h00);
		set_msg_len(32'd2);
		push_req(OP_START, 8'h00);
		push_req(OP_DATA, 8'hFF);
		push_req(OP_DATA, 8'h80);
		// full group, sender pause mid-message, then a byte past the end
		set_msg_len(32'd3);
		push_req(OP_START, 8'h00);
		push_req(OP_DATA, 8'hFF);
		wait_text_drained();
		push_req(OP_DATA, 8'h00);
		push_req(OP_DATA, 8'hA5);
		push_req(OP_DATA, 8'h5A);
		// restart during a message
		set_msg_len(32'd4);
		push_req(OP_START, 8'h00);
		push_req(OP_DATA, 8'h01);
		push_req(OP_DATA, 8'h02);
		push_req(OP_START, 8'hFF);
		push_req(OP_DATA, 8'hFE);
		push_req(OP_DATA, 8'h7F);
		push_req(OP_DATA, 8'h80);
		push_req(OP_DATA, 8'h3C);
		set_msg_len(32'hFFFF_FFFF);
		push_req(OP_START, 8'h00);
		push_req(OP_DATA, 8'hFF);
		push_req(OP_DATA, 8'hFF);
		push_req(OP_DATA, 8'hFF);

		rand_items = 0;
		first      = 1'b1;
		while (rand_items < RAND_ITEMS) begin
			if (first) begin
				len = 32'd120;
			end else begin
				case ($urandom_range(0, 15))
					0:                len = 32'd0;
					1, 2, 3, 4, 5:    len = $urandom_range(1, 12);
					6, 7, 8:          len = $urandom_range(40, 50);
					9, 10:            len = $urandom_range(85, 95);
					11:               len = 32'd135;
					12:               len = 32'hFFFF_FFFF;
					13:               len = $urandom;
					default:          len = $urandom_range(1, 30);
				endcase
			end
			nb = (len > 140) ? $urandom_range(20, 60) : int'(len);
			pause_at   = -1;
			restart_at = -1;
			noise      = 1'b0;
			if (!first) begin
				if (len != 0 && len <= 140 && $urandom_range(0, 4) == 0)
					nb = $urandom_range(0, int'(len) - 1);
				else if ($urandom_range(0, 5) == 0)
					nb = nb + $urandom_range(1, 3);
				noise = ($urandom_range(0, 5) == 0);
				if (nb > 1 && $urandom_range(0, 7) == 0)
					pause_at = $urandom_range(1, nb - 1);
				if (nb > 1 && $urandom_range(0, 7) == 0)
					restart_at = $urandom_range(1, nb - 1);
			end
			set_msg_len(len);
			if (first)
				long_armed = 1'b1;
			queue_message(len, nb, noise, pause_at, restart_at, n);
			rand_items += n;
			first = 1'b0;
		end

		wait_text_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
hdl/uuse_pkg.sv
hdl/uuse_in_if.sv
hdl/uuse_out_if.sv
hdl/uuse_cfg_if.sv
hdl/uuse_front.sv
hdl/uuse_queue.sv
hdl/uuse_back.sv
hdl/uuencode_stream_encoder.sv
tb/sv/tb_top.sv
